>>> design/ttce_pkg.sv
// Shared types and constants of the terminal cursor engine.
package ttce_pkg;

    localparam int MAX_RES   = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_FIRST = 8'd32;
    localparam logic [7:0] CH_LAST  = 8'd126;

    localparam logic [7:0] ECHO_RESET   = 8'd1;
    localparam logic [7:0] PERIOD_RESET = 8'd10;

    typedef enum logic [1:0] {
        CMD_RX   = 2'd0,
        CMD_KEY  = 2'd1,
        CMD_TICK = 2'd2,
        CMD_SHOW = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        OP_DRAW    = 3'd0,
        OP_CLEAR   = 3'd1,
        OP_CUR_ON  = 3'd2,
        OP_CUR_OFF = 3'd3,
        OP_SCROLL  = 3'd4,
        OP_TX      = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        BC_NONE,
        BC_PRINT,
        BC_CR,
        BC_LF,
        BC_BS
    } bclass_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOCAL_ECHO   = 1'd0,
        REG_BLINK_PERIOD = 1'd1
    } reg_idx_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data_byte;
    } req_t;

    typedef struct packed {
        op_t        op;
        logic [6:0] col;
        logic [4:0] row;
        logic [7:0] glyph;
        logic       last;
    } res_t;

    // Classified request handed from front to back
    typedef struct packed {
        kind_t      kind;
        logic [1:0] tx_cnt;
        logic [7:0] byte_a;
        bclass_t    class_a;
        logic [7:0] byte_b;
        bclass_t    class_b;
    } cls_t;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] index;
        logic [7:0]           data;
    } cfg_wr_t;

endpackage

>>> design/text_terminal_cursor_engine.sv
// Top level of the terminal cursor engine: intake, queue and execution.
// Usage:
//   req channel (req_valid / req_stall / req): one request per accepted beat,
//   cmd selects received byte, key byte, timer tick or cursor show.
//   res channel (res_valid / res_stall / res): display commands and UART
//   transmit bytes in order; last marks the final command of a request.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): register 0 is
//   local echo, register 1 the blink period; cfg_ready is always high and
//   writes should land only while the engine is idle.
// Path: a request's first command passes through the queue register and then
//   the output buffer register before it is valid on res.
// Throughput: a request occupies the execution stage until its k commands (0
//   to 5) are taken from the output buffer, which sends one command per cycle
//   unless res_stall holds it; the next request loads in the cycle the last
//   command is taken.
// The two-entry request queue raises req_stall only when full.
// While res_stall is high the current command holds and the queue fills.
// Reset: cursor at column 0 of the bottom row, hidden, blink counter clear,
//   local echo on, blink period 10, queue and output empty.
module text_terminal_cursor_engine #(
    parameter int NUM_COLS = 72,
    parameter int NUM_ROWS = 18
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  ttce_pkg::req_t                 req,
    output logic                           res_valid,
    input  logic                           res_stall,
    output ttce_pkg::res_t                 res,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ttce_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data
);

    logic              push, q_full, q_pop, q_avail;
    ttce_pkg::cls_t    cls, q_item;
    ttce_pkg::cfg_wr_t cfg;

    assign cfg_ready = 1'b1;
    assign req_stall = q_full;
    assign cfg.we    = cfg_valid && cfg_ready;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    ttce_front u_front (
        .req       (req),
        .req_valid (req_valid),
        .q_full    (q_full),
        .push      (push),
        .cls       (cls)
    );

    ttce_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (cls),
        .full  (q_full),
        .pop   (q_pop),
        .avail (q_avail),
        .dout  (q_item)
    );

    ttce_back #(
        .NUM_COLS (NUM_COLS),
        .NUM_ROWS (NUM_ROWS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_avail   (q_avail),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule

>>> design/ttce_front.sv
// Request intake: decodes each request into a classified command.
module ttce_front (
    input  ttce_pkg::req_t req,
    input  logic           req_valid,
    input  logic           q_full,
    output logic           push,
    output ttce_pkg::cls_t cls
);

    function automatic ttce_pkg::bclass_t classify(logic [7:0] b);
        ttce_pkg::bclass_t c;
        c = ttce_pkg::BC_NONE;
        if (b == ttce_pkg::CH_CR)
            c = ttce_pkg::BC_CR;
        else if (b == ttce_pkg::CH_LF)
            c = ttce_pkg::BC_LF;
        else if (b == ttce_pkg::CH_BS)
            c = ttce_pkg::BC_BS;
        else if (b >= ttce_pkg::CH_FIRST && b <= ttce_pkg::CH_LAST)
            c = ttce_pkg::BC_PRINT;
        return c;
    endfunction

    ttce_pkg::bclass_t data_class;

    assign data_class = classify(req.data_byte);
    assign push       = req_valid && !q_full;

    always_comb
    begin
        cls         = '0;
        cls.kind    = ttce_pkg::kind_t'(req.cmd);
        cls.byte_a  = req.data_byte;
        cls.class_a = data_class;
        cls.byte_b  = ttce_pkg::CH_LF;
        cls.class_b = ttce_pkg::BC_LF;
        if (cls.kind == ttce_pkg::CMD_KEY)
        begin
            case (data_class)
                // Enter goes out as CR then LF
                ttce_pkg::BC_LF:
                begin
                    cls.tx_cnt  = 2'd2;
                    cls.byte_a  = ttce_pkg::CH_CR;
                    cls.class_a = ttce_pkg::BC_CR;
                end
                ttce_pkg::BC_PRINT, ttce_pkg::BC_BS: cls.tx_cnt = 2'd1;
                default: cls.tx_cnt = 2'd0;
            endcase
        end
    end

endmodule

>>> design/ttce_queue.sv
// Two-entry queue of classified requests between front and back.
module ttce_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ttce_pkg::cls_t din,
    output logic           full,
    input  logic           pop,
    output logic           avail,
    output ttce_pkg::cls_t dout
);

    ttce_pkg::cls_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign avail = (count_reg != 2'd0);
    assign dout  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= din;
    end

endmodule

>>> design/ttce_back.sv
// Execution side: cursor state, command list build and result output.
module ttce_back #(
    parameter int NUM_COLS = 72,
    parameter int NUM_ROWS = 18
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_avail,
    input  ttce_pkg::cls_t    q_item,
    output logic              q_pop,
    input  ttce_pkg::cfg_wr_t cfg,
    output logic              res_valid,
    input  logic              res_stall,
    output ttce_pkg::res_t    res
);

    localparam logic [6:0] LAST_COL = 7'(NUM_COLS - 1);
    localparam logic [4:0] LAST_ROW = 5'(NUM_ROWS - 1);
    localparam int         NCAND    = 8;

    typedef struct packed {
        logic           va;
        ttce_pkg::res_t ra;
        logic           vb;
        ttce_pkg::res_t rb;
        logic [6:0]     col;
        logic [4:0]     line;
    } print_t;

    function automatic print_t print_byte(ttce_pkg::bclass_t bc, logic [7:0] b,
                                          logic [6:0] c, logic [4:0] l);
        print_t p;
        p      = '0;
        p.col  = c;
        p.line = l;
        case (bc)
            ttce_pkg::BC_CR: p.col = 7'd0;
            ttce_pkg::BC_LF:
            begin
                p.col = 7'd0;
                if (l == LAST_ROW)
                begin
                    p.va    = 1'b1;
                    p.ra.op = ttce_pkg::OP_SCROLL;
                end
                else
                    p.line = l + 5'd1;
            end
            ttce_pkg::BC_BS:
            begin
                // Nothing to erase at the left margin
                if (c != 7'd0)
                begin
                    p.col    = c - 7'd1;
                    p.va     = 1'b1;
                    p.ra.op  = ttce_pkg::OP_CLEAR;
                    p.ra.col = c - 7'd1;
                    p.ra.row = l;
                end
            end
            ttce_pkg::BC_PRINT:
            begin
                p.va       = 1'b1;
                p.ra.op    = ttce_pkg::OP_DRAW;
                p.ra.col   = c;
                p.ra.row   = l;
                p.ra.glyph = b;
                if (c == LAST_COL)
                begin
                    p.col = 7'd0;
                    if (l == LAST_ROW)
                    begin
                        p.vb    = 1'b1;
                        p.rb.op = ttce_pkg::OP_SCROLL;
                    end
                    else
                        p.line = l + 5'd1;
                end
                else
                    p.col = c + 7'd1;
            end
            default: ;
        endcase
        return p;
    endfunction

    ttce_pkg::res_t buf_reg [ttce_pkg::MAX_RES];
    ttce_pkg::res_t buf_next [ttce_pkg::MAX_RES];
    logic [2:0] rem_reg, rem_next;
    logic [6:0] col_reg, col_next;
    logic [4:0] line_reg, line_next;
    logic       shown_reg, shown_next;
    logic [7:0] blink_reg, blink_next;
    logic       echo_reg, echo_next;
    logic [7:0] period_reg, period_next;

    print_t         pa, pb;
    ttce_pkg::res_t cand [NCAND];
    logic [NCAND-1:0] cv;
    ttce_pkg::res_t lst [ttce_pkg::MAX_RES];
    logic [2:0]     n;
    logic [7:0]     blink_inc;
    logic           is_key, take, load;

    assign res_valid = (rem_reg != 3'd0);
    assign res       = buf_reg[0];
    assign take      = res_valid && !res_stall;
    assign load      = q_avail && (rem_reg == 3'd0 || (rem_reg == 3'd1 && take));
    assign q_pop     = load;

    assign is_key    = (q_item.kind == ttce_pkg::CMD_KEY);
    assign blink_inc = blink_reg + 8'd1;

    // Build the command list of the request at the head of the queue
    always_comb
    begin
        cand = '{default: '0};
        cv   = '0;
        col_next   = col_reg;
        line_next  = line_reg;
        shown_next = shown_reg;
        blink_next = blink_reg;

        pa = print_byte(q_item.class_a, q_item.byte_a, col_reg, line_reg);
        pb = print_byte(q_item.class_b, q_item.byte_b, pa.col, pa.line);

        // Hide the cursor before touching the screen
        cand[0].op  = ttce_pkg::OP_CUR_OFF;
        cand[0].col = col_reg;
        cand[0].row = line_reg;
        cand[1].op    = ttce_pkg::OP_TX;
        cand[1].glyph = q_item.byte_a;
        cand[2] = pa.ra;
        cand[3] = pa.rb;
        cand[4].op    = ttce_pkg::OP_TX;
        cand[4].glyph = q_item.byte_b;
        cand[5] = pb.ra;
        cand[6] = pb.rb;
        cand[7].op = ttce_pkg::OP_CUR_ON;

        case (q_item.kind)
            ttce_pkg::CMD_RX, ttce_pkg::CMD_KEY:
            begin
                logic print_a, print_b;
                print_a = !is_key || (echo_reg && q_item.tx_cnt != 2'd0);
                print_b = is_key && echo_reg && q_item.tx_cnt == 2'd2;
                cv[0] = shown_reg;
                cv[1] = is_key && q_item.tx_cnt != 2'd0;
                cv[2] = print_a && pa.va;
                cv[3] = print_a && pa.vb;
                cv[4] = is_key && q_item.tx_cnt == 2'd2;
                cv[5] = print_b && pb.va;
                cv[6] = print_b && pb.vb;
                cv[7] = 1'b1;
                if (print_b)
                begin
                    col_next  = pb.col;
                    line_next = pb.line;
                end
                else if (print_a)
                begin
                    col_next  = pa.col;
                    line_next = pa.line;
                end
                cand[7].col = col_next;
                cand[7].row = line_next;
                shown_next  = 1'b1;
            end
            ttce_pkg::CMD_TICK:
            begin
                blink_next = blink_inc;
                if (blink_inc >= period_reg)
                begin
                    blink_next  = 8'd0;
                    cv[7]       = 1'b1;
                    cand[7].op  = shown_reg ? ttce_pkg::OP_CUR_OFF : ttce_pkg::OP_CUR_ON;
                    cand[7].col = col_reg;
                    cand[7].row = line_reg;
                    shown_next  = !shown_reg;
                end
            end
            default:
            begin
                col_next    = 7'd0;
                line_next   = LAST_ROW;
                shown_next  = 1'b1;
                cv[7]       = 1'b1;
                cand[7].col = 7'd0;
                cand[7].row = LAST_ROW;
            end
        endcase

        // Pack the active entries in order
        lst = '{default: '0};
        n   = 3'd0;
        for (int i = 0; i < NCAND; i++)
        begin
            if (cv[i] && n < 3'(ttce_pkg::MAX_RES))
            begin
                lst[n] = cand[i];
                n      = n + 3'd1;
            end
        end
        if (n != 3'd0)
            lst[n - 3'd1].last = 1'b1;
    end

    always_comb
    begin
        echo_next   = echo_reg;
        period_next = period_reg;
        if (cfg.we)
        begin
            case (ttce_pkg::reg_idx_t'(cfg.index))
                ttce_pkg::REG_LOCAL_ECHO:   echo_next   = cfg.data[0];
                ttce_pkg::REG_BLINK_PERIOD: period_next = cfg.data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        buf_next = buf_reg;
        rem_next = rem_reg;
        if (load)
        begin
            buf_next = lst;
            rem_next = n;
        end
        else if (take)
        begin
            // Advance the output list by one
            for (int i = 0; i < ttce_pkg::MAX_RES - 1; i++)
                buf_next[i] = buf_reg[i + 1];
            rem_next = rem_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg    <= 3'd0;
            col_reg    <= 7'd0;
            line_reg   <= LAST_ROW;
            shown_reg  <= 1'b0;
            blink_reg  <= 8'd0;
            echo_reg   <= ttce_pkg::ECHO_RESET[0];
            period_reg <= ttce_pkg::PERIOD_RESET;
        end
        else
        begin
            rem_reg    <= rem_next;
            echo_reg   <= echo_next;
            period_reg <= period_next;
            if (load)
            begin
                col_reg   <= col_next;
                line_reg  <= line_next;
                shown_reg <= shown_next;
                blink_reg <= blink_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

endmodule

>>> design/ttce_checker.sv
// Port-level checks of the terminal cursor engine and their binding.
module ttce_checker #(
    parameter int NUM_COLS = 72,
    parameter int NUM_ROWS = 18
) (
    input logic           clk,
    input logic           rst_n,
    input logic           res_valid,
    input logic           res_stall,
    input ttce_pkg::res_t res
);

    // A stalled command holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("stalled result changed");

    // Commands of one request follow without gaps
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_stall && !res.last |=> res_valid)
        else $error("gap inside a request's commands");

    a_cell_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.op != ttce_pkg::OP_SCROLL && res.op != ttce_pkg::OP_TX
        |-> {1'b0, res.col} < 8'(NUM_COLS) && {1'b0, res.row} < 6'(NUM_ROWS))
        else $error("cell outside the screen");

    a_no_pos: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res.op == ttce_pkg::OP_SCROLL || res.op == ttce_pkg::OP_TX)
        |-> res.col == 7'd0 && res.row == 5'd0)
        else $error("scroll or transmit carries a cell");

endmodule

bind text_terminal_cursor_engine ttce_checker #(
    .NUM_COLS (NUM_COLS),
    .NUM_ROWS (NUM_ROWS)
) u_ttce_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);

>>> bench/text_terminal_cursor_engine_test.sv
// Self-checking testbench for the terminal cursor engine.
`timescale 1ns / 1ps

module text_terminal_cursor_engine_test;

    localparam int NUM_COLS   = 72;
    localparam int NUM_ROWS   = 18;
    localparam int SETTLE     = 8;
    localparam int QUIET_MAX  = 2000;
    localparam int PHASE_REQS = 85;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           req_valid = 1'b0;
    logic                           req_stall;
    ttce_pkg::req_t                 req       = '0;
    logic                           res_valid;
    logic                           res_stall = 1'b0;
    ttce_pkg::res_t                 res;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [ttce_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]                     cfg_data  = '0;

    // Shadow of the engine state
    logic       echo_on;
    logic [7:0] blink_period_q;
    logic [6:0] cur_col;
    logic [4:0] cur_row;
    logic       cur_shown;
    logic [7:0] blink_count;

    ttce_pkg::res_t due_cmds[$];
    ttce_pkg::res_t batch[$];
    ttce_pkg::res_t head_cmd;

    int errors     = 0;
    int cmd_seen   = 0;
    int quiet      = 0;
    int send_idle  = 0;
    int recv_stall = 0;

    text_terminal_cursor_engine #(
        .NUM_COLS(NUM_COLS),
        .NUM_ROWS(NUM_ROWS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res(res),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    task report(input string msg);
        $display("MISMATCH: %s", msg);
        errors++;
    endtask

    function automatic logic printable(input logic [7:0] b);
        return b >= ttce_pkg::CH_FIRST && b <= ttce_pkg::CH_LAST;
    endfunction

    task add_cmd(input ttce_pkg::op_t op, input logic [6:0] c, input logic [4:0] r,
                 input logic [7:0] g);
        ttce_pkg::res_t item;
        item.op    = op;
        item.col   = c;
        item.row   = r;
        item.glyph = g;
        item.last  = 1'b0;
        batch.push_back(item);
    endtask

    task set_cursor(input logic vis);
        if (cur_shown != vis)
        begin
            if (vis)
                add_cmd(ttce_pkg::OP_CUR_ON, cur_col, cur_row, 8'd0);
            else
                add_cmd(ttce_pkg::OP_CUR_OFF, cur_col, cur_row, 8'd0);
        end
        cur_shown = vis;
    endtask

    task advance_line;
        if (cur_row >= NUM_ROWS - 1)
        begin
            add_cmd(ttce_pkg::OP_SCROLL, 7'd0, 5'd0, 8'd0);
            cur_row = 5'(NUM_ROWS - 1);
        end
        else
            cur_row = cur_row + 5'd1;
    endtask

    task print_char(input logic [7:0] b);
        if (b == ttce_pkg::CH_CR)
            cur_col = '0;
        else if (b == ttce_pkg::CH_LF)
        begin
            cur_col = '0;
            advance_line();
        end
        else if (b == ttce_pkg::CH_BS)
        begin
            if (cur_col > 0)
            begin
                cur_col = cur_col - 7'd1;
                add_cmd(ttce_pkg::OP_CLEAR, cur_col, cur_row, 8'd0);
            end
        end
        else if (printable(b))
        begin
            add_cmd(ttce_pkg::OP_DRAW, cur_col, cur_row, b);
            if (cur_col >= NUM_COLS - 1)
            begin
                cur_col = '0;
                advance_line();
            end
            else
                cur_col = cur_col + 7'd1;
        end
    endtask

    task send_byte(input logic [7:0] b);
        add_cmd(ttce_pkg::OP_TX, 7'd0, 5'd0, b);
        if (echo_on)
            print_char(b);
    endtask

    // Work out the display and transmit commands of one accepted request
    task predict_commands(input ttce_pkg::req_t rq);
        ttce_pkg::res_t due;
        batch = {};
        case (rq.cmd)
            ttce_pkg::CMD_RX:
            begin
                set_cursor(1'b0);
                print_char(rq.data_byte);
                set_cursor(1'b1);
            end
            ttce_pkg::CMD_KEY:
            begin
                set_cursor(1'b0);
                if (rq.data_byte == ttce_pkg::CH_LF)
                begin
                    send_byte(ttce_pkg::CH_CR);
                    send_byte(ttce_pkg::CH_LF);
                end
                else if (printable(rq.data_byte) || rq.data_byte == ttce_pkg::CH_BS)
                    send_byte(rq.data_byte);
                set_cursor(1'b1);
            end
            ttce_pkg::CMD_TICK:
            begin
                blink_count = blink_count + 8'd1;
                if (blink_count >= blink_period_q)
                begin
                    blink_count = '0;
                    set_cursor(!cur_shown);
                end
            end
            default:
            begin
                cur_col   = '0;
                cur_row   = 5'(NUM_ROWS - 1);
                cur_shown = 1'b0;
                set_cursor(1'b1);
            end
        endcase
        foreach (batch[i])
        begin
            due      = batch[i];
            due.last = (i == batch.size() - 1);
            due_cmds.push_back(due);
        end
    endtask

    task send_request(input ttce_pkg::kind_t kind, input logic [7:0] data);
        ttce_pkg::req_t rq;
        rq.cmd       = kind;
        rq.data_byte = data;
        @(negedge clk);
        while ($urandom_range(99) < send_idle)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= rq;
        do
            @(posedge clk);
        while (req_stall);
        predict_commands(rq);
    endtask

    // Hold off new requests until every expected command has come out
    task drain;
        @(negedge clk);
        req_valid <= 1'b0;
        while (due_cmds.size() != 0)
            @(posedge clk);
    endtask

    task write_register(input ttce_pkg::reg_idx_t idx, input logic [7:0] value);
        drain();
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            ttce_pkg::REG_LOCAL_ECHO:   echo_on = value[0];
            ttce_pkg::REG_BLINK_PERIOD: blink_period_q = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    always @(negedge clk)
        res_stall <= ($urandom_range(99) < recv_stall);

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            cmd_seen++;
            if (due_cmds.size() == 0)
                report($sformatf("command %0d not expected: op=%0d col=%0d row=%0d",
                                 cmd_seen, res.op, res.col, res.row));
            else
            begin
                head_cmd = due_cmds.pop_front();
                if (res.op !== head_cmd.op)
                    report($sformatf("command %0d op %0d, want %0d",
                                     cmd_seen, res.op, head_cmd.op));
                if (res.col !== head_cmd.col)
                    report($sformatf("command %0d col %0d, want %0d",
                                     cmd_seen, res.col, head_cmd.col));
                if (res.row !== head_cmd.row)
                    report($sformatf("command %0d row %0d, want %0d",
                                     cmd_seen, res.row, head_cmd.row));
                if (res.glyph !== head_cmd.glyph)
                    report($sformatf("command %0d glyph %0h, want %0h",
                                     cmd_seen, res.glyph, head_cmd.glyph));
                if (res.last !== head_cmd.last)
                    report($sformatf("command %0d last %0b, want %0b",
                                     cmd_seen, res.last, head_cmd.last));
            end
        end
    end

    // Give up when the handshakes go quiet for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (res_valid && !res_stall) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_MAX)
            begin
                $display("watchdog: no handshake for %0d cycles", quiet);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task test_received_bytes;
        send_request(ttce_pkg::CMD_RX, "A");
        send_request(ttce_pkg::CMD_RX, ttce_pkg::CH_FIRST);
        send_request(ttce_pkg::CMD_RX, ttce_pkg::CH_LAST);
        send_request(ttce_pkg::CMD_RX, 8'd31);
        send_request(ttce_pkg::CMD_RX, 8'd127);
        send_request(ttce_pkg::CMD_RX, 8'hFF);
        send_request(ttce_pkg::CMD_RX, 8'h00);
        send_request(ttce_pkg::CMD_RX, ttce_pkg::CH_CR);
        send_request(ttce_pkg::CMD_RX, ttce_pkg::CH_BS);
        send_request(ttce_pkg::CMD_RX, "x");
        send_request(ttce_pkg::CMD_RX, ttce_pkg::CH_BS);
        send_request(ttce_pkg::CMD_RX, ttce_pkg::CH_LF);
    endtask

    task test_keys;
        write_register(ttce_pkg::REG_LOCAL_ECHO, 8'd1);
        send_request(ttce_pkg::CMD_KEY, "k");
        send_request(ttce_pkg::CMD_KEY, ttce_pkg::CH_LF);
        send_request(ttce_pkg::CMD_KEY, ttce_pkg::CH_CR);
        send_request(ttce_pkg::CMD_KEY, ttce_pkg::CH_BS);
        send_request(ttce_pkg::CMD_KEY, 8'h80);
        send_request(ttce_pkg::CMD_KEY, 8'h1B);
        write_register(ttce_pkg::REG_LOCAL_ECHO, 8'd0);
        send_request(ttce_pkg::CMD_KEY, "q");
        send_request(ttce_pkg::CMD_KEY, ttce_pkg::CH_LF);
        send_request(ttce_pkg::CMD_KEY, ttce_pkg::CH_BS);
        write_register(ttce_pkg::REG_LOCAL_ECHO, 8'd1);
    endtask

    task test_show;
        send_request(ttce_pkg::CMD_RX, "s");
        send_request(ttce_pkg::CMD_SHOW, 8'hFF);
        send_request(ttce_pkg::CMD_SHOW, 8'h00);
        send_request(ttce_pkg::CMD_RX, "t");
    endtask

    task test_wrap_and_scroll;
        send_request(ttce_pkg::CMD_RX, ttce_pkg::CH_CR);
        repeat (NUM_COLS + 3)
            send_request(ttce_pkg::CMD_RX,
                         8'($urandom_range(ttce_pkg::CH_LAST, ttce_pkg::CH_FIRST)));
        send_request(ttce_pkg::CMD_RX, ttce_pkg::CH_BS);
    endtask

    task test_blink;
        write_register(ttce_pkg::REG_BLINK_PERIOD, 8'd1);
        repeat (3) send_request(ttce_pkg::CMD_TICK, 8'($urandom));
        write_register(ttce_pkg::REG_BLINK_PERIOD, 8'd40);
        repeat (40) send_request(ttce_pkg::CMD_TICK, 8'($urandom));
        repeat (20) send_request(ttce_pkg::CMD_TICK, 8'($urandom));
        // counter already past the new period: next tick toggles
        write_register(ttce_pkg::REG_BLINK_PERIOD, 8'd3);
        send_request(ttce_pkg::CMD_TICK, 8'h00);
        send_request(ttce_pkg::CMD_RX, "b");
        repeat (4) send_request(ttce_pkg::CMD_TICK, 8'hFF);
        write_register(ttce_pkg::REG_BLINK_PERIOD, ttce_pkg::PERIOD_RESET);
    endtask

    task automatic send_random_request;
        int     pick;
        int     sel;
        logic [7:0] b;
        pick = $urandom_range(99);
        sel  = $urandom_range(99);
        if (sel < 70)
            b = 8'($urandom_range(ttce_pkg::CH_LAST, ttce_pkg::CH_FIRST));
        else if (sel < 78)
            b = ttce_pkg::CH_LF;
        else if (sel < 83)
            b = ttce_pkg::CH_CR;
        else if (sel < 91)
            b = ttce_pkg::CH_BS;
        else
            b = 8'($urandom);
        if (pick < 55)
            send_request(ttce_pkg::CMD_RX, b);
        else if (pick < 75)
            send_request(ttce_pkg::CMD_KEY, b);
        else if (pick < 95)
            send_request(ttce_pkg::CMD_TICK, 8'($urandom));
        else
            send_request(ttce_pkg::CMD_SHOW, 8'($urandom));
    endtask

    task test_random_traffic;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    write_register(ttce_pkg::REG_LOCAL_ECHO, 8'd1);
                    write_register(ttce_pkg::REG_BLINK_PERIOD, 8'd1);
                    send_idle  = 0;
                    recv_stall = 0;
                end
                1:
                begin
                    write_register(ttce_pkg::REG_LOCAL_ECHO, 8'd0);
                    write_register(ttce_pkg::REG_BLINK_PERIOD, 8'($urandom_range(20, 2)));
                    send_idle  = 79;
                    recv_stall = 0;
                end
                2:
                begin
                    write_register(ttce_pkg::REG_LOCAL_ECHO, 8'd1);
                    write_register(ttce_pkg::REG_BLINK_PERIOD, 8'd255);
                    send_idle  = 0;
                    recv_stall = 79;
                end
                default:
                begin
                    write_register(ttce_pkg::REG_LOCAL_ECHO, 8'($urandom_range(1)));
                    write_register(ttce_pkg::REG_BLINK_PERIOD, 8'($urandom_range(12, 1)));
                    send_idle  = 6;
                    recv_stall = 6;
                end
            endcase
            for (int n = 0; n < PHASE_REQS; n++)
            begin
                if ($urandom_range(49) == 0)
                    drain();
                send_random_request();
            end
        end
    endtask

    initial
    begin
        echo_on        = ttce_pkg::ECHO_RESET[0];
        blink_period_q = ttce_pkg::PERIOD_RESET;
        cur_col        = '0;
        cur_row        = 5'(NUM_ROWS - 1);
        cur_shown      = 1'b0;
        blink_count    = '0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_received_bytes();
        test_keys();
        test_show();
        test_wrap_and_scroll();
        test_blink();
        test_random_traffic();

        drain();
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
